// ===== rtl/ssi_pkg.sv =====
// Shared widths and word types for the segment intersection core.
package ssi_pkg;

  localparam int CW  = 16;          // coordinate width
  localparam int DW  = CW + 1;      // coordinate differences
  localparam int CRW = 2 * CW + 3;  // cross products, signed
  localparam int NW  = 3 * CW + 4;  // scaled point numerators, signed
  localparam int QB  = CW + 1;      // quotient magnitude bits, one per divider cell

  typedef struct packed {
    logic signed [CW-1:0] ray_start_x;
    logic signed [CW-1:0] ray_start_y;
    logic signed [CW-1:0] ray_dir_x;
    logic signed [CW-1:0] ray_dir_y;
    logic signed [CW-1:0] seg_a_x;
    logic signed [CW-1:0] seg_a_y;
    logic signed [CW-1:0] seg_b_x;
    logic signed [CW-1:0] seg_b_y;
  } coord_t;

  typedef struct packed {
    logic          hit;
    logic          neg_x;
    logic          neg_y;
    logic [NW-1:0] rem_x;
    logic [NW-1:0] rem_y;
    logic [NW-1:0] dsh;
    logic [QB-1:0] quo_x;
    logic [QB-1:0] quo_y;
  } div_word_t;

endpackage

// ===== rtl/ssi_front.sv =====
// Front pipeline: cross products, hit test and scaled point numerators.
module ssi_front import ssi_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  coord_t    coord_i,
  output logic      valid_o,
  output div_word_t word_o
);

  logic [6:0] vld_q;

  // stage 1
  logic signed [DW-1:0] dx_q, dy_q, qx_q, qy_q;
  logic signed [CW-1:0] px1_q, py1_q, rx1_q, ry1_q;
  // stage 2
  logic signed [CRW-1:0] rxdy_q, rydx_q, qxdy_q, qydx_q, qxry_q, qyrx_q;
  logic signed [CW-1:0]  px2_q, py2_q, rx2_q, ry2_q;
  // stage 3
  logic signed [CRW-1:0] den_q, tn_q, un_q;
  logic signed [CW-1:0]  px3_q, py3_q, rx3_q, ry3_q;
  // stage 4
  logic signed [CRW-1:0] den_d, tn_d, un_d, den4_q, tn4_q;
  logic                  hit_d, hit4_q;
  logic signed [CW-1:0]  px4_q, py4_q, rx4_q, ry4_q;
  // stage 5
  logic signed [NW-1:0]  mx_q, my_q, tx_q, ty_q;
  logic signed [CRW-1:0] den5_q;
  logic                  hit5_q;
  // stage 6
  logic signed [NW-1:0]  nx_q, ny_q;
  logic signed [CRW-1:0] den6_q;
  logic                  hit6_q;
  // stage 7
  div_word_t             word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[5:0], valid_i};
    end
  end

  // normalise signs so that den is positive, then test both parameters in [0,1]
  always_comb begin
    den_d = den_q[CRW-1] ? -den_q : den_q;
    tn_d  = den_q[CRW-1] ? -tn_q  : tn_q;
    un_d  = den_q[CRW-1] ? -un_q  : un_q;
    hit_d = (den_q != '0) && !tn_d[CRW-1] && (tn_d <= den_d) &&
            !un_d[CRW-1] && (un_d <= den_d);
  end

  always_ff @(posedge clk_i) begin
    dx_q  <= DW'(coord_i.seg_b_x) - DW'(coord_i.seg_a_x);
    dy_q  <= DW'(coord_i.seg_b_y) - DW'(coord_i.seg_a_y);
    qx_q  <= DW'(coord_i.seg_a_x) - DW'(coord_i.ray_start_x);
    qy_q  <= DW'(coord_i.seg_a_y) - DW'(coord_i.ray_start_y);
    px1_q <= coord_i.ray_start_x;
    py1_q <= coord_i.ray_start_y;
    rx1_q <= coord_i.ray_dir_x;
    ry1_q <= coord_i.ray_dir_y;

    rxdy_q <= CRW'(rx1_q) * CRW'(dy_q);
    rydx_q <= CRW'(ry1_q) * CRW'(dx_q);
    qxdy_q <= CRW'(qx_q) * CRW'(dy_q);
    qydx_q <= CRW'(qy_q) * CRW'(dx_q);
    qxry_q <= CRW'(qx_q) * CRW'(ry1_q);
    qyrx_q <= CRW'(qy_q) * CRW'(rx1_q);
    px2_q <= px1_q; py2_q <= py1_q; rx2_q <= rx1_q; ry2_q <= ry1_q;

    den_q <= rxdy_q - rydx_q;
    tn_q  <= qxdy_q - qydx_q;
    un_q  <= qxry_q - qyrx_q;
    px3_q <= px2_q; py3_q <= py2_q; rx3_q <= rx2_q; ry3_q <= ry2_q;

    den4_q <= den_d;
    tn4_q  <= tn_d;
    hit4_q <= hit_d;
    px4_q <= px3_q; py4_q <= py3_q; rx4_q <= rx3_q; ry4_q <= ry3_q;

    mx_q   <= NW'(px4_q) * NW'(den4_q);
    my_q   <= NW'(py4_q) * NW'(den4_q);
    tx_q   <= NW'(rx4_q) * NW'(tn4_q);
    ty_q   <= NW'(ry4_q) * NW'(tn4_q);
    den5_q <= den4_q;
    hit5_q <= hit4_q;

    nx_q   <= mx_q + tx_q;
    ny_q   <= my_q + ty_q;
    den6_q <= den5_q;
    hit6_q <= hit5_q;

    word_q.hit   <= hit6_q;
    word_q.neg_x <= nx_q[NW-1];
    word_q.neg_y <= ny_q[NW-1];
    word_q.rem_x <= nx_q[NW-1] ? -nx_q : nx_q;
    word_q.rem_y <= ny_q[NW-1] ? -ny_q : ny_q;
    word_q.dsh   <= NW'(den6_q) << (QB - 1);
    word_q.quo_x <= '0;
    word_q.quo_y <= '0;
  end

  assign valid_o = vld_q[6];
  assign word_o  = word_q;

endmodule

// ===== rtl/ssi_div_cell.sv =====
// One restoring division cell: settle one quotient bit for x and y.
module ssi_div_cell import ssi_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  div_word_t word_i,
  output logic      valid_o,
  output div_word_t word_o
);

  logic      valid_q;
  div_word_t word_d, word_q;
  logic      ge_x, ge_y;

  always_comb begin
    ge_x         = word_i.rem_x >= word_i.dsh;
    ge_y         = word_i.rem_y >= word_i.dsh;
    word_d       = word_i;
    word_d.rem_x = ge_x ? word_i.rem_x - word_i.dsh : word_i.rem_x;
    word_d.rem_y = ge_y ? word_i.rem_y - word_i.dsh : word_i.rem_y;
    word_d.dsh   = word_i.dsh >> 1;
    word_d.quo_x = {word_i.quo_x[QB-2:0], ge_x};
    word_d.quo_y = {word_i.quo_y[QB-2:0], ge_y};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// ===== rtl/segment_segment_intersect_core.sv =====
// Top level of the ray segment against wall segment intersection core.
// Path: the 7-stage front pipeline, one divider cell per quotient bit, then an output register.
// Throughput: one word per cycle; busy is never raised, the pipeline never stalls.
// Reset: asynchronous, active low; clears all valid flags and the hit flag, the rest of the payload is left unreset.
module segment_segment_intersect_core import ssi_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [CW-1:0] ray_start_x_i,
  input  logic signed [CW-1:0] ray_start_y_i,
  input  logic signed [CW-1:0] ray_dir_x_i,
  input  logic signed [CW-1:0] ray_dir_y_i,
  input  logic signed [CW-1:0] seg_a_x_i,
  input  logic signed [CW-1:0] seg_a_y_i,
  input  logic signed [CW-1:0] seg_b_x_i,
  input  logic signed [CW-1:0] seg_b_y_i,
  output logic                 valid_o,
  output logic                 hit_o,
  output logic signed [CW-1:0] point_x_o,
  output logic signed [CW-1:0] point_y_o
);

  localparam int LAT = QB + 8;

  coord_t    coord;
  logic      vld_c [QB+1];
  div_word_t word_c [QB+1];
  logic [QB-1:0] qx_s, qy_s;

  logic                 valid_q, hit_q;
  logic signed [CW-1:0] point_x_q, point_y_q;

  // the pipeline never holds off a word
  assign busy = 1'b0;

  assign coord.ray_start_x = ray_start_x_i;
  assign coord.ray_start_y = ray_start_y_i;
  assign coord.ray_dir_x   = ray_dir_x_i;
  assign coord.ray_dir_y   = ray_dir_y_i;
  assign coord.seg_a_x     = seg_a_x_i;
  assign coord.seg_a_y     = seg_a_y_i;
  assign coord.seg_b_x     = seg_b_x_i;
  assign coord.seg_b_y     = seg_b_y_i;

  ssi_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start & ~busy),
    .coord_i (coord),
    .valid_o (vld_c[0]),
    .word_o  (word_c[0])
  );

  // chain of divider cells, most significant quotient bit first
  for (genvar g = 0; g < QB; g++) begin : g_cell
    ssi_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld_c[g]),
      .word_i  (word_c[g]),
      .valid_o (vld_c[g+1]),
      .word_o  (word_c[g+1])
    );
  end

  // restore the sign of each quotient, truncated toward zero
  assign qx_s = word_c[QB].neg_x ? -word_c[QB].quo_x : word_c[QB].quo_x;
  assign qy_s = word_c[QB].neg_y ? -word_c[QB].quo_y : word_c[QB].quo_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      valid_q <= vld_c[QB];
      hit_q   <= vld_c[QB] & word_c[QB].hit;
    end
  end

  // drop the point to zero on a miss
  always_ff @(posedge clk_i) begin
    point_x_q <= word_c[QB].hit ? qx_s[CW-1:0] : '0;
    point_y_q <= word_c[QB].hit ? qy_s[CW-1:0] : '0;
  end

  assign valid_o   = valid_q;
  assign hit_o     = hit_q;
  assign point_x_o = point_x_q;
  assign point_y_o = point_y_q;

`ifndef SYNTHESIS
  a_result_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start & ~busy, LAT))
    else $error("result word without an accepted word");
  a_hit_only_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_o |-> valid_o)
    else $error("hit flagged outside a result word");
`endif

endmodule

// ===== bench/segment_segment_intersect_core_tb.sv =====
// Self-checking bench for the segment intersection core: predicts each result and compares.
module segment_segment_intersect_core_tb;
  import ssi_pkg::*;

  typedef logic signed [CW-1:0] coord_word_t;

  // One expected result word.
  typedef struct {
    logic        hit;
    coord_word_t px;
    coord_word_t py;
  } isect_t;

  // Scoreboard: predict the intersection of each accepted word and check results in order.
  class isect_board;
    isect_t pending[$];
    int     errors;

    function new();
      errors = 0;
    endfunction

    // Work out the hit and point exactly; no division is needed for the bounds tests.
    function void note_word(coord_t w);
      isect_t     e;
      longint     px, py, rx, ry, dx, dy, qx, qy, den, tn, un;
      longint     nx, ny;
      px = longint'(w.ray_start_x); py = longint'(w.ray_start_y);
      rx = longint'(w.ray_dir_x);   ry = longint'(w.ray_dir_y);
      dx = longint'(w.seg_b_x) - longint'(w.seg_a_x);
      dy = longint'(w.seg_b_y) - longint'(w.seg_a_y);
      qx = longint'(w.seg_a_x) - px;
      qy = longint'(w.seg_a_y) - py;
      den = rx * dy - ry * dx;
      tn  = qx * dy - qy * dx;
      un  = qx * ry - qy * rx;
      e.hit = 1'b0; e.px = '0; e.py = '0;
      if (den != 0) begin
        // normalise signs so that den is positive
        if (den < 0) begin
          den = -den; tn = -tn; un = -un;
        end
        e.hit = (tn >= 0) && (tn <= den) && (un >= 0) && (un <= den);
      end
      if (e.hit) begin
        // |den*p| and |tn*r| stay below 2^52, so 64 bits hold the numerators
        nx = den * px + tn * rx;
        ny = den * py + tn * ry;
        e.px = coord_word_t'(nx / den);   // SV division truncates toward zero
        e.py = coord_word_t'(ny / den);
      end
      pending.push_back(e);
    endfunction

    function void check_result(logic hit, coord_word_t x, coord_word_t y);
      isect_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result hit=%0b x=%0d y=%0d", $time, hit, x, y);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (hit !== e.hit) begin
        $display("%0t: hit expected %0b actual %0b", $time, e.hit, hit);
        errors++;
      end
      if (x !== e.px) begin
        $display("%0t: point_x expected %0d actual %0d", $time, e.px, x);
        errors++;
      end
      if (y !== e.py) begin
        $display("%0t: point_y expected %0d actual %0d", $time, e.py, y);
        errors++;
      end
    endfunction
  endclass

  localparam int LATENCY    = CW + 9;
  localparam int STALL_LIM  = 2000;
  localparam int RAND_WORDS = 1430;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  coord_t      word_q = '0;
  logic        valid, hit;
  coord_word_t point_x, point_y;

  isect_board board = new();
  int         idle_cycles = 0;
  bit         allow_gaps = 1'b1;

  always #5 clk = ~clk;

  segment_segment_intersect_core dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start        (start),
    .busy         (busy),
    .ray_start_x_i(word_q.ray_start_x),
    .ray_start_y_i(word_q.ray_start_y),
    .ray_dir_x_i  (word_q.ray_dir_x),
    .ray_dir_y_i  (word_q.ray_dir_y),
    .seg_a_x_i    (word_q.seg_a_x),
    .seg_a_y_i    (word_q.seg_a_y),
    .seg_b_x_i    (word_q.seg_b_x),
    .seg_b_y_i    (word_q.seg_b_y),
    .valid_o      (valid),
    .hit_o        (hit),
    .point_x_o    (point_x),
    .point_y_o    (point_y)
  );

  // Sample results and count idle cycles at each edge; the result strobe cannot be held off.
  always @(posedge clk) begin
    if (rst_n) begin
      if (valid) board.check_result(hit, point_x, point_y);
      if ((start && !busy) || valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (idle_cycles >= STALL_LIM) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offer one word and hold it until accepted; optionally insert an idle burst first.
  task automatic send_word(coord_t w);
    int gap;
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    word_q <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_word(w);
  endtask

  task automatic drop_start();
    start <= 1'b0;
    @(posedge clk);
  endtask

  // Build a word from p, r, a, b.
  function automatic coord_t mk(int px, int py, int rx, int ry,
                                int ax, int ay, int bx, int by);
    coord_t w;
    w.ray_start_x = CW'(px); w.ray_start_y = CW'(py);
    w.ray_dir_x   = CW'(rx); w.ray_dir_y   = CW'(ry);
    w.seg_a_x     = CW'(ax); w.seg_a_y     = CW'(ay);
    w.seg_b_x     = CW'(bx); w.seg_b_y     = CW'(by);
    return w;
  endfunction

  function automatic int rnd_coord();
    return int'($signed(16'($urandom)));
  endfunction

  function automatic int rnd_near(int c, int span);
    int v;
    v = c + $signed($urandom_range(0, 2 * span)) - span;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  // Random word: mostly a wall straddling the ray so that hits are common.
  function automatic coord_t rnd_word();
    int kind, span, px, py, rx, ry, mx, my, ax, ay;
    kind = $urandom_range(0, 9);
    span = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(1, 300);
    if (kind < 2)
      return mk(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
    px = rnd_near(0, span); py = rnd_near(0, span);
    rx = rnd_near(0, span); ry = rnd_near(0, span);
    if (kind == 2) begin
      // parallel wall: b - a is a multiple of r
      ax = rnd_near(px, span); ay = rnd_near(py, span);
      return mk(px, py, rx, ry, ax, ay, rnd_near(ax + rx, 0), rnd_near(ay + ry, 0));
    end
    if (kind == 3)
      // wall touching the ray end point
      return mk(px, py, rx, ry, rnd_near(px + rx, 0), rnd_near(py + ry, 0),
                rnd_near(px, span), rnd_near(py, span));
    // wall around a point on the ray
    mx = rnd_near(px + rx / 2, span / 4); my = rnd_near(py + ry / 2, span / 4);
    ax = rnd_near(mx, span); ay = rnd_near(my, span);
    return mk(px, py, rx, ry, ax, ay, rnd_near(2 * mx - ax, 2), rnd_near(2 * my - ay, 2));
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: crossing, end point touches, parallel, collinear, zero lengths, extremes.
    send_word(mk(0, 0, 10, 10, 0, 10, 10, 0));
    send_word(mk(0, 0, 10, 0, 10, -5, 10, 5));
    send_word(mk(0, 0, 10, 0, 5, 0, 5, 7));
    send_word(mk(0, 0, 10, 0, 11, -5, 11, 5));
    send_word(mk(0, 0, 10, 0, 0, 1, 10, 1));
    send_word(mk(0, 0, 10, 0, 3, 0, 20, 0));
    send_word(mk(3, 3, 0, 0, 0, 0, 6, 6));
    send_word(mk(0, 0, 10, 10, 4, 4, 4, 4));
    send_word(mk(-5, -5, 3, 7, 7, -9, -6, 4));
    send_word(mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_word(mk(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767));
    send_word(mk(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
    send_word(mk(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
    send_word(mk(0, 0, -1, -1, -32768, -32768, 32767, 32767));
    send_word(mk(-1, -1, -1, -1, -1, -1, -1, -1));
    send_word(mk(0, 0, 7, 3, 0, 5, 7, -2));
    send_word(mk(0, 0, 7, 3, 7, 3, 14, 9));
    send_word(mk(1, 2, -7, -3, -6, 9, -5, -20));

    // Hold off until every expected word is back.
    drop_start();
    while (board.pending.size() != 0) @(posedge clk);

    for (int i = 0; i < RAND_WORDS; i++) begin
      if (i == RAND_WORDS - 200) allow_gaps = 1'b0;
      send_word(rnd_word());
    end
    drop_start();

    while (board.pending.size() != 0 && idle_cycles < STALL_LIM) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== segment_segment_intersect_core.f =====
rtl/ssi_pkg.sv
rtl/ssi_front.sv
rtl/ssi_div_cell.sv
rtl/segment_segment_intersect_core.sv
bench/segment_segment_intersect_core_tb.sv
